// File: hw/rtl/dial_mask_matcher_defines.svh
// Assertion macros shared by the dial mask matcher.
// Every macro expects clk and rst in the scope where it is used.
`ifndef DIAL_MASK_MATCHER_DEFINES_SVH
`define DIAL_MASK_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dmm_pkg.sv
`default_nettype none

package dmm_pkg;

  localparam int DIGIT_W     = 4;
  localparam int DIGITS_W    = 64;
  localparam int COUNT_W     = 5;
  localparam int ID_W        = 16;
  localparam int ID_WORD_W   = 64;
  localparam int ALLOW_CNT_W = 4;
  localparam int VERDICT_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam logic [DIGIT_W-1:0] WILDCARD_CODE = 4'hF;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NOT_MATCH     = 2'd0,
    VERDICT_NOT_COMPLETED = 2'd1,
    VERDICT_COMPLETED     = 2'd2,
    VERDICT_NOT_ALLOWED   = 2'd3
  } verdict_t;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_MASK_DIGITS      = 3'd0;
  localparam cfg_index_t CFG_MASK_LENGTH      = 3'd1;
  localparam cfg_index_t CFG_ALLOWED_IDS_LOW  = 3'd2;
  localparam cfg_index_t CFG_ALLOWED_IDS_HIGH = 3'd3;
  localparam cfg_index_t CFG_ALLOWED_COUNT    = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/dmm_if.sv
`default_nettype none

// Input channel: one dialing snapshot per item.
interface dmm_in_if;
  import dmm_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGITS_W-1:0] dialed_digits;
  logic [COUNT_W-1:0]  dialed_count;
  logic [ID_W-1:0]     caller_id;

  modport source (output valid, output dialed_digits, output dialed_count,
                  output caller_id, input ready);
  modport sink   (input valid, input dialed_digits, input dialed_count,
                  input caller_id, output ready);
endinterface

// Output channel: one verdict per item.
interface dmm_out_if;
  import dmm_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dial_mask_matcher.sv
`default_nettype none

// Dial mask matcher. Each input item carries the digits dialed so far on a line, how many
// there are, and the caller's client id; the block answers every item with exactly one
// verdict: not_match, not_completed, completed or not_allowed. The mask, its length and
// the allow-list are set through the write port (index 0 mask digits, 1 mask length,
// 2 and 3 the allow-list words, 4 the allow-list count) and should be written only while
// no item is in flight. One item is taken every clock cycle unless a waiting verdict is
// not taken; the input stays ready while a finished verdict waits, if the output side
// takes it in the same cycle. A verdict appears in the output register the cycle after
// acceptance, from one register stage behind the parallel digit and id compare lanes.
`include "dial_mask_matcher_defines.svh"

module dial_mask_matcher #(
  parameter int MAX_DIGITS  = 16,
  parameter int MAX_CLIENTS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dmm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dmm_pkg::CFG_DATA_W-1:0]  cfg_data,
  dmm_in_if.sink                              in_ch,
  dmm_out_if.source                           out_ch
);
  import dmm_pkg::*;

  // Configuration registers, all cleared by reset.
  logic [DIGITS_W-1:0]    mask_digits;
  logic [COUNT_W-1:0]     mask_length;
  logic [ID_WORD_W-1:0]   allowed_ids_low;
  logic [ID_WORD_W-1:0]   allowed_ids_high;
  logic [ALLOW_CNT_W-1:0] allowed_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_digits      <= '0;
      mask_length      <= '0;
      allowed_ids_low  <= '0;
      allowed_ids_high <= '0;
      allowed_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK_DIGITS:      mask_digits      <= cfg_data;
        CFG_MASK_LENGTH:      mask_length      <= cfg_data[COUNT_W-1:0];
        CFG_ALLOWED_IDS_LOW:  allowed_ids_low  <= cfg_data;
        CFG_ALLOWED_IDS_HIGH: allowed_ids_high <= cfg_data;
        CFG_ALLOWED_COUNT:    allowed_count    <= cfg_data[ALLOW_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Lengths beyond what the lanes cover are clamped to the lane count.
  logic [COUNT_W-1:0]     mask_len_eff;
  logic [ALLOW_CNT_W-1:0] allow_cnt_eff;

  assign mask_len_eff  = (mask_length > COUNT_W'(MAX_DIGITS)) ?
                         COUNT_W'(MAX_DIGITS) : mask_length;
  assign allow_cnt_eff = (allowed_count > ALLOW_CNT_W'(MAX_CLIENTS)) ?
                         ALLOW_CNT_W'(MAX_CLIENTS) : allowed_count;

  // One digit lane per mask position; each flags a mismatch at its own position.
  logic [MAX_DIGITS-1:0] mismatch;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_digit
    dmm_digit_lane #(.POS(i)) u_lane (
      .mask_code    (mask_digits[i*DIGIT_W +: DIGIT_W]),
      .dialed_code  (in_ch.dialed_digits[i*DIGIT_W +: DIGIT_W]),
      .dialed_count (in_ch.dialed_count),
      .mismatch     (mismatch[i])
    );
  end

  // One id lane per allow-list entry; entries 0 to 3 sit in the low word.
  logic [2*ID_WORD_W-1:0] all_ids;
  logic [MAX_CLIENTS-1:0] hit;

  assign all_ids = {allowed_ids_high, allowed_ids_low};

  for (genvar k = 0; k < MAX_CLIENTS; k++) begin : g_id
    dmm_id_lane #(.IDX(k)) u_lane (
      .entry       (all_ids[k*ID_W +: ID_W]),
      .caller_id   (in_ch.caller_id),
      .allow_count (allow_cnt_eff),
      .hit         (hit[k])
    );
  end

  verdict_t verdict_next;

  dmm_merge #(
    .MAX_DIGITS  (MAX_DIGITS),
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_merge (
    .mismatch     (mismatch),
    .hit          (hit),
    .dialed_count (in_ch.dialed_count),
    .mask_len     (mask_len_eff),
    .verdict      (verdict_next)
  );

  // Output register. A new item may enter whenever the register is empty or
  // its verdict is being taken in the same cycle.
  logic     out_valid;
  verdict_t verdict;
  logic     in_accept;

  assign in_ch.ready    = !out_valid || out_ch.ready;
  assign in_accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.verdict = verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      verdict <= verdict_next;
    end
  end

  // An accepted item always leaves a verdict in the output register.
  `DMM_ASSERT_NEXT(a_accept_fills, in_accept, out_ch.valid, "accepted item produced no verdict")
  // Dialing past the mask length can never end in anything but a mismatch.
  `DMM_ASSERT_NEXT(a_long_dial, in_accept && (in_ch.dialed_count > mask_len_eff), out_ch.verdict == VERDICT_NOT_MATCH, "too many digits did not give not_match")
  // An empty output register never holds back the input.
  `DMM_ASSERT_SAME(a_ready_empty, !out_ch.valid, in_ch.ready, "input stalled with empty output")

endmodule

`default_nettype wire

// File: hw/rtl/dmm_digit_lane.sv
`default_nettype none

// Compares one dialed position with its mask code.
module dmm_digit_lane #(
  parameter int POS = 0
) (
  input  wire logic [dmm_pkg::DIGIT_W-1:0] mask_code,
  input  wire logic [dmm_pkg::DIGIT_W-1:0] dialed_code,
  input  wire logic [dmm_pkg::COUNT_W-1:0] dialed_count,
  output logic                             mismatch
);
  import dmm_pkg::*;

  logic active;

  // Only positions below the dialed count take part in the compare.
  assign active   = dialed_count > COUNT_W'(POS);
  assign mismatch = active && (mask_code != WILDCARD_CODE) && (mask_code != dialed_code);
endmodule

`default_nettype wire

// File: hw/rtl/dmm_id_lane.sv
`default_nettype none

// Compares the caller id with one allow-list entry.
module dmm_id_lane #(
  parameter int IDX = 0
) (
  input  wire logic [dmm_pkg::ID_W-1:0]        entry,
  input  wire logic [dmm_pkg::ID_W-1:0]        caller_id,
  input  wire logic [dmm_pkg::ALLOW_CNT_W-1:0] allow_count,
  output logic                                 hit
);
  import dmm_pkg::*;

  assign hit = (allow_count > ALLOW_CNT_W'(IDX)) && (entry == caller_id);
endmodule

`default_nettype wire

// File: hw/rtl/dmm_merge.sv
`default_nettype none

// Combines the digit and id lane results into one verdict.
module dmm_merge #(
  parameter int MAX_DIGITS  = 16,
  parameter int MAX_CLIENTS = 8
) (
  input  wire logic [MAX_DIGITS-1:0]       mismatch,
  input  wire logic [MAX_CLIENTS-1:0]      hit,
  input  wire logic [dmm_pkg::COUNT_W-1:0] dialed_count,
  input  wire logic [dmm_pkg::COUNT_W-1:0] mask_len,
  output dmm_pkg::verdict_t                verdict
);
  import dmm_pkg::*;

  logic too_long;
  logic full_length;

  assign too_long    = dialed_count > mask_len;
  assign full_length = dialed_count == mask_len;

  always_comb begin
    if (too_long || (|mismatch)) begin
      verdict = VERDICT_NOT_MATCH;
    end else if (!full_length) begin
      verdict = VERDICT_NOT_COMPLETED;
    end else if (|hit) begin
      verdict = VERDICT_COMPLETED;
    end else begin
      verdict = VERDICT_NOT_ALLOWED;
    end
  end
endmodule

`default_nettype wire
